### rtl/core/two_port_mac_learning_filter_top_assert.svh
// Assertion macros for the learning filter.
`ifndef TWO_PORT_MAC_LEARNING_FILTER_TOP_ASSERT_SVH
`define TWO_PORT_MAC_LEARNING_FILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPMLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPMLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpmlf_pkg.sv
`default_nettype none
package tpmlf_pkg;

  localparam int MAC_W = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT0_OWN_MAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT1_OWN_MAC = 2'd1;

  typedef enum logic [1:0] {
    VERDICT_FORWARD    = 2'd0,
    VERDICT_OWN_MAC    = 2'd1,
    VERDICT_OTHER_PORT = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OWN,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic scan_rd;
    logic set_own;
    logic set_hit;
    logic set_miss;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic own_hit;
    logic empty;
    logic match;
    logic scan_last;
  } status_t;

endpackage
`default_nettype wire

### rtl/core/tpmlf_ctrl.sv
`default_nettype none
module tpmlf_ctrl
  import tpmlf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_OWN;
      end
      ST_OWN: begin
        if (status.own_hit || status.empty) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.match || status.scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in = in_tvalid;
      end
      ST_OWN: begin
        if (status.own_hit) cmd.set_own = 1'b1;
        else if (status.empty) cmd.set_miss = 1'b1;
        else cmd.scan_rd = 1'b1;
      end
      ST_SCAN: begin
        if (status.match) cmd.set_hit = 1'b1;
        else if (status.scan_last) cmd.set_miss = 1'b1;
        else cmd.scan_rd = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

### rtl/core/tpmlf_dp.sv
`default_nettype none
module tpmlf_dp
  import tpmlf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAC_W-1:0]     cfg_data,
  input  wire logic [MAC_W-1:0]     in_mac,
  input  wire logic                 in_port,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic [7:0]                out_tdata
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  logic [MAC_W:0]   entry_mem_r [TABLE_ENTRIES];
  logic [MAC_W-1:0] own0_r, own1_r;
  logic [MAC_W-1:0] mac_r;
  logic             port_r;
  logic [AW-1:0]    idx_r, rd_idx_r;
  logic [MAC_W:0]   rd_data_r;
  logic [CW-1:0]    count_r;
  verdict_t         res_verdict_r;
  logic             res_egress_r, res_learned_r, res_full_r;
  logic             table_has_room;

  assign table_has_room = (count_r != FULL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own0_r  <= '0;
      own1_r  <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_PORT0_OWN_MAC) own0_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_PORT1_OWN_MAC) own1_r <= cfg_data;
      if (cmd.set_miss && table_has_room) count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_miss && table_has_room) begin
      entry_mem_r[count_r[AW-1:0]] <= {port_r, mac_r};
    end
    if (cmd.scan_rd) begin
      rd_data_r <= entry_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mac_r  <= in_mac;
      port_r <= in_port;
      idx_r  <= '0;
    end else if (cmd.scan_rd) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.scan_rd) rd_idx_r <= idx_r;

    if (cmd.set_own) begin
      res_verdict_r <= VERDICT_OWN_MAC;
      res_egress_r  <= 1'b0;
      res_learned_r <= 1'b0;
      res_full_r    <= 1'b0;
    end else if (cmd.set_hit) begin
      res_learned_r <= 1'b0;
      res_full_r    <= 1'b0;
      if (rd_data_r[MAC_W] != port_r) begin
        res_verdict_r <= VERDICT_OTHER_PORT;
        res_egress_r  <= 1'b0;
      end else begin
        res_verdict_r <= VERDICT_FORWARD;
        res_egress_r  <= ~port_r;
      end
    end else if (cmd.set_miss) begin
      res_verdict_r <= VERDICT_FORWARD;
      res_egress_r  <= ~port_r;
      res_learned_r <= table_has_room;
      res_full_r    <= ~table_has_room;
    end

    if (cmd.load_out) begin
      out_tdata <= {3'b000, res_full_r, res_learned_r, res_egress_r, res_verdict_r};
    end
  end

  assign status.own_hit   = (mac_r == own0_r) || (mac_r == own1_r);
  assign status.empty     = (count_r == '0);
  assign status.match     = (rd_data_r[MAC_W-1:0] == mac_r);
  assign status.scan_last = ((CW'(rd_idx_r) + CW'(1)) == count_r);

endmodule
`default_nettype wire

### rtl/core/two_port_mac_learning_filter_top.sv
`default_nettype none
// Source-MAC learning filter for a two-port bridge. Each input item carries a
// frame's source MAC and the port it came in on; the block answers with one
// item holding the verdict, the egress port, and flags for a new table entry
// or a full table. The lookup reads the learning table one entry per cycle
// through a single registered read port: a miss scans every filled entry,
// a hit stops at the matching entry, and a frame matching an own MAC or
// meeting an empty table skips the scan. The block takes one item at a time;
// a stalled result holds off the next item until the output is free.
// The table starts empty after reset with no clearing pass; entries are never
// aged out. Own MAC registers may only be written while the block is idle.
module two_port_mac_learning_filter_top
  import tpmlf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAC_W-1:0]     cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [MAC_W-1:0]     in_tdata,   // [47:0] source_mac
  input  wire logic                 in_tuser,   // [0] ingress_port
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata   // [1:0] verdict, [2] egress_port,
                                                // [3] newly_learned, [4] table_full
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tpmlf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tpmlf_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mac    (in_tdata),
    .in_port   (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

`include "two_port_mac_learning_filter_top_assert.svh"

  `TPMLF_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "accepted an item while busy")
  `TPMLF_ASSERT_NOW(a_drop_has_no_flags, out_tvalid && out_tdata[1:0] != VERDICT_FORWARD, out_tdata[4:2] == 3'b000, "dropped item carries flags")
  `TPMLF_ASSERT_NOW(a_one_decision, cmd.set_miss || cmd.set_hit || cmd.set_own, $onehot({cmd.set_miss, cmd.set_hit, cmd.set_own}), "conflicting decisions")

endmodule
`default_nettype wire
